FILE: design/cfa_pkg.sv
// Package: shared types, constants and helper functions of the contact force allocator.
`default_nettype none

package cfa_pkg;

  // Default configuration
  localparam int unsigned LEG_COUNT_DEF   = 6;
  localparam int unsigned SOLVE_STEPS_DEF = 80;

  // Field widths
  localparam int unsigned F_W       = 32;  // force, Q24.8
  localparam int unsigned ARM_W     = 12;  // lever arm, cm
  localparam int unsigned RATIO_W   = 16;  // ratio, Q2.14
  localparam int unsigned BLEND_W   = 17;  // blend, Q1.16
  localparam int unsigned LEG_NUM_W = 3;

  // Datapath widths, sized for the largest leg count (16)
  localparam int unsigned SUMF_W = 38;
  localparam int unsigned SUMR_W = 53;
  localparam int unsigned RES_W  = 41;
  localparam int unsigned PROD_W = 57;
  localparam int unsigned DOT_W  = 44;
  localparam int unsigned NEWF_W = 46;
  localparam int unsigned BPRD_W = 52;
  localparam int unsigned NIB_CNT = DOT_W / 4;  // digits of the divide by 40

  // Constants
  localparam int unsigned BLEND_ONE  = 65536;
  localparam int unsigned STEP_DIV   = 40;        // step gain 0.025
  localparam int unsigned STEP_BIAS  = STEP_DIV - 1;
  localparam int unsigned RECIP_125  = 34359739;  // ceil(2^32 / 125)
  localparam int unsigned ROUND_BIAS = 62;
  localparam int unsigned RECIP_5    = 205;       // ~2^10 / 5
  localparam int unsigned RATIO_SH   = 14;
  localparam int unsigned BLEND_SH   = 16;

  typedef struct packed {
    logic signed [ARM_W-1:0] arm_x;
    logic signed [ARM_W-1:0] arm_y;
    logic                    in_contact;
    logic [F_W-1:0]          demand_lift;
    logic signed [F_W-1:0]   demand_roll;
    logic signed [F_W-1:0]   demand_pitch;
    logic [BLEND_W-1:0]      blend;
    logic                    last_leg;
  } in_item_t;

  typedef struct packed {
    logic [LEG_NUM_W-1:0] leg_number;
    logic [F_W-1:0]       support_force;
    logic                 last;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic acc_en;
    logic res_en;
    logic mul_en;
    logic dot_en;
    logic div_en;
    logic upd_en;
    logic bmul_en;
    logic bout_en;
  } cmd_t;

  typedef struct packed {
    logic contact;
    logic in_last;
    logic out_free;
  } sts_t;

  // round(cm * 16384 / 500), saturated to the ratio range
  function automatic logic signed [RATIO_W-1:0] make_ratio(input logic signed [ARM_W:0] cm);
    logic [ARM_W:0]            mag;
    logic [24:0]               v;
    logic [49:0]               p;
    logic [17:0]               q;
    logic signed [RATIO_W-1:0] r;
    mag = cm[ARM_W] ? (ARM_W+1)'(-cm) : (ARM_W+1)'(cm);
    v   = {mag, 12'd0} + 25'(ROUND_BIAS);
    p   = 50'(v) * 50'(RECIP_125);
    q   = p[49:32];
    if (cm[ARM_W]) begin
      r = (q >= 18'h08000) ? 16'sh8000 : -$signed(RATIO_W'(q));
    end else begin
      r = (q > 18'h07fff) ? 16'sh7fff : $signed(RATIO_W'(q));
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: design/contact_force_allocator.sv
// Top level: contact force allocator, controller plus datapath.
//
// Usage
//   Input channel (in_valid_i / in_ready_o / in_data_i): one transaction per leg,
//   in leg order. The transaction with last_leg set closes the run, supplies the
//   demands and blend, and starts the solve; earlier ones are taken whenever the block is idle.
//   Output channel (out_valid_o / out_ready_i / out_data_o): after a solve,
//   LEG_COUNT result transactions, leg 0 first, last set on the final one.
//   Configuration (cfg_valid_i / cfg_ready_o / cfg_data_i): force limit, always
//   ready; write only while the block is idle.
// Solve sequence
//   Solve: SOLVE_STEPS passes, each an accumulation over all legs and a residual
//   step, then for each leg in contact a multiply, dot, eleven-digit divide by 40
//   and update; a leg out of contact is skipped. Blending and output run leg by
//   leg: blend multiply, then an output load that waits for a free output slot.
// Reset
//   Stored forces, contact mask and leg counter clear; force limit to all ones.
// Stall
//   A stalled receiver holds the output register; the next result waits in the
//   datapath and the block takes no input until the run's results are loaded.
`default_nettype none

module contact_force_allocator #(
  parameter int unsigned LEG_COUNT   = cfa_pkg::LEG_COUNT_DEF,
  parameter int unsigned SOLVE_STEPS = cfa_pkg::SOLVE_STEPS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [31:0]        cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire cfa_pkg::in_item_t  in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output cfa_pkg::out_item_t      out_data_o
);
  import cfa_pkg::*;

  localparam int unsigned IDX_W = $clog2(LEG_COUNT);

  cmd_t             cmd;
  sts_t             sts;
  logic [IDX_W-1:0] leg;

  // The limit register takes a write in any cycle.
  assign cfg_ready_o = 1'b1;

  cfa_ctrl #(
    .LEG_COUNT  (LEG_COUNT),
    .SOLVE_STEPS(SOLVE_STEPS),
    .IDX_W      (IDX_W)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .sts_i     (sts),
    .cmd_o     (cmd),
    .leg_o     (leg)
  );

  cfa_dp #(
    .LEG_COUNT(LEG_COUNT),
    .IDX_W    (IDX_W)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .leg_i      (leg),
    .sts_o      (sts),
    .out_ready_i(out_ready_i),
    .out_valid_o(out_valid_o),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire

FILE: design/cfa_dp.sv
// Datapath: leg tables, gradient solve arithmetic, blend and output register.
`default_nettype none

module cfa_dp #(
  parameter int unsigned LEG_COUNT = 6,
  parameter int unsigned IDX_W     = 3
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_valid_i,
  input  wire logic [31:0]       cfg_data_i,
  input  wire cfa_pkg::in_item_t in_data_i,
  input  wire cfa_pkg::cmd_t     cmd_i,
  input  wire logic [IDX_W-1:0]  leg_i,
  output cfa_pkg::sts_t          sts_o,
  input  wire logic              out_ready_i,
  output logic                   out_valid_o,
  output cfa_pkg::out_item_t     out_data_o
);
  import cfa_pkg::*;

  logic [F_W-1:0]            limit_q;
  logic [F_W-1:0]            stored_q [LEG_COUNT];
  logic [LEG_COUNT-1:0]      contact_q;
  logic [IDX_W-1:0]          leg_cnt_q;
  logic                      out_valid_q;
  out_item_t                 out_q;

  logic [F_W-1:0]            w_q     [LEG_COUNT];
  logic signed [RATIO_W-1:0] roll_q  [LEG_COUNT];
  logic signed [RATIO_W-1:0] pitch_q [LEG_COUNT];
  logic [F_W-1:0]            lift_q;
  logic signed [F_W-1:0]     droll_q, dpitch_q;
  logic [BLEND_W-1:0]        bl_q;
  logic signed [SUMF_W-1:0]  sumf_q;
  logic signed [SUMR_W-1:0]  sumr_q, sump_q;
  logic signed [RES_W-1:0]   resl_q, resr_q, resp_q;
  logic signed [PROD_W-1:0]  prr_q, prp_q;
  logic                      neg_q;
  logic [DOT_W-1:0]          u_q, quot_q;
  logic [2:0]                rem_q;
  logic signed [BPRD_W-1:0]  bprod_q;

  logic [IDX_W-1:0]          slot;
  logic                      slot_end;
  logic [BLEND_W-1:0]        bl_sat;
  logic [F_W-1:0]            w_cur, s_cur;
  logic signed [48:0]        acc_r, acc_p;
  logic signed [PROD_W-1:0]  mul_r, mul_p;
  logic signed [DOT_W-1:0]   dot, mag;
  logic [6:0]                dv;
  logic [14:0]               dq_prod;
  logic [3:0]                dq;
  logic [2:0]                drem;
  logic signed [NEWF_W-1:0]  qs, fnew;
  logic [F_W-1:0]            fclamp;
  logic signed [F_W+1:0]     diff, nb;
  logic signed [BPRD_W-1:0]  bmul;
  logic [F_W-1:0]            bclamp;

  always_comb begin
    slot     = leg_cnt_q;
    slot_end = (leg_cnt_q == IDX_W'(LEG_COUNT - 1));
    bl_sat   = (in_data_i.blend > BLEND_W'(BLEND_ONE)) ? BLEND_W'(BLEND_ONE) : in_data_i.blend;
    w_cur    = w_q[leg_i];
    s_cur    = stored_q[leg_i];
    acc_r    = roll_q[leg_i] * $signed({1'b0, w_cur});
    acc_p    = pitch_q[leg_i] * $signed({1'b0, w_cur});
    mul_r    = roll_q[leg_i] * resr_q;
    mul_p    = pitch_q[leg_i] * resp_q;
    dot      = DOT_W'(resl_q) + DOT_W'(prr_q >>> RATIO_SH) + DOT_W'(prp_q >>> RATIO_SH);
    // floor(dot / 40): work on a magnitude, rounded so the result floors
    mag      = dot[DOT_W-1] ? (-dot + DOT_W'(STEP_BIAS)) : dot;
    dv       = {rem_q, u_q[DOT_W-1 -: 4]};
    dq_prod  = 15'(dv) * 15'(RECIP_5);
    dq       = dq_prod[13:10];
    drem     = 3'(dv - 7'(dq) * 7'd5);
    qs       = $signed(NEWF_W'(quot_q));
    if (neg_q) begin
      qs = -qs;
    end
    fnew     = $signed(NEWF_W'(w_cur)) + qs;
    if (fnew[NEWF_W-1]) begin
      fclamp = '0;
    end else if (fnew > $signed(NEWF_W'(limit_q))) begin
      fclamp = limit_q;
    end else begin
      fclamp = F_W'(fnew);
    end
    diff     = $signed({2'b00, w_cur}) - $signed({2'b00, s_cur});
    bmul     = diff * $signed({1'b0, bl_q});
    nb       = $signed({2'b00, s_cur}) + (F_W+2)'(bprod_q >>> BLEND_SH);
    if (nb[F_W+1]) begin
      bclamp = '0;
    end else if (nb[F_W]) begin
      bclamp = '1;
    end else begin
      bclamp = F_W'(nb);
    end
  end

  // Control and reset state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= '1;
      contact_q   <= '0;
      leg_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < LEG_COUNT; i++) begin
        stored_q[i] <= '0;
      end
    end else begin
      if (cfg_valid_i) begin
        limit_q <= cfg_data_i;
      end
      if (cmd_i.accept) begin
        contact_q[slot] <= in_data_i.in_contact;
        leg_cnt_q       <= (in_data_i.last_leg || slot_end) ? '0 : slot + 1'b1;
      end
      if (cmd_i.bout_en) begin
        stored_q[leg_i] <= contact_q[leg_i] ? bclamp : '0;
        out_valid_q     <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working data
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      roll_q[slot]  <= make_ratio((ARM_W+1)'(in_data_i.arm_y));
      pitch_q[slot] <= make_ratio(-((ARM_W+1)'(in_data_i.arm_x)));
      if (in_data_i.last_leg) begin
        lift_q   <= in_data_i.demand_lift;
        droll_q  <= in_data_i.demand_roll;
        dpitch_q <= in_data_i.demand_pitch;
        bl_q     <= bl_sat;
        sumf_q   <= '0;
        sumr_q   <= '0;
        sump_q   <= '0;
        for (int i = 0; i < LEG_COUNT; i++) begin
          w_q[i] <= stored_q[i];
        end
      end
    end
    if (cmd_i.acc_en && contact_q[leg_i]) begin
      sumf_q <= sumf_q + $signed(SUMF_W'(w_cur));
      sumr_q <= sumr_q + SUMR_W'(acc_r);
      sump_q <= sump_q + SUMR_W'(acc_p);
    end
    if (cmd_i.res_en) begin
      resl_q <= $signed(RES_W'(lift_q)) - RES_W'(sumf_q);
      resr_q <= RES_W'(droll_q) - RES_W'(sumr_q >>> RATIO_SH);
      resp_q <= RES_W'(dpitch_q) - RES_W'(sump_q >>> RATIO_SH);
      sumf_q <= '0;
      sumr_q <= '0;
      sump_q <= '0;
    end
    if (cmd_i.mul_en) begin
      prr_q <= mul_r;
      prp_q <= mul_p;
    end
    if (cmd_i.dot_en) begin
      neg_q  <= dot[DOT_W-1];
      u_q    <= DOT_W'(mag >> 3);
      rem_q  <= '0;
      quot_q <= '0;
    end
    if (cmd_i.div_en) begin
      u_q    <= u_q << 4;
      rem_q  <= drem;
      quot_q <= {quot_q[DOT_W-5:0], dq};
    end
    if (cmd_i.upd_en) begin
      w_q[leg_i] <= fclamp;
    end
    if (cmd_i.bmul_en) begin
      bprod_q <= bmul;
    end
    if (cmd_i.bout_en) begin
      out_q.leg_number    <= LEG_NUM_W'(leg_i);
      out_q.support_force <= contact_q[leg_i] ? bclamp : '0;
      out_q.last          <= (leg_i == IDX_W'(LEG_COUNT - 1));
    end
  end

  assign sts_o.contact  = contact_q[leg_i];
  assign sts_o.in_last  = in_data_i.last_leg;
  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_q;

endmodule

`default_nettype wire

FILE: design/cfa_ctrl.sv
// Controller: sequences leg intake, solve passes, blending and result output.
`default_nettype none

module cfa_ctrl #(
  parameter int unsigned LEG_COUNT   = 6,
  parameter int unsigned SOLVE_STEPS = 80,
  parameter int unsigned IDX_W       = 3
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire cfa_pkg::sts_t sts_i,
  output cfa_pkg::cmd_t      cmd_o,
  output logic [IDX_W-1:0]   leg_o
);
  import cfa_pkg::*;

  localparam int unsigned STEP_W  = $clog2(SOLVE_STEPS + 1);
  localparam int unsigned DIGIT_W = $clog2(NIB_CNT);

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_ACC  = 9'b000000010,
    ST_RES  = 9'b000000100,
    ST_MUL  = 9'b000001000,
    ST_DOT  = 9'b000010000,
    ST_DIV  = 9'b000100000,
    ST_UPD  = 9'b001000000,
    ST_BMUL = 9'b010000000,
    ST_BOUT = 9'b100000000
  } state_e;

  state_e             state_q, state_d;
  logic [IDX_W-1:0]   leg_q, leg_d;
  logic [STEP_W-1:0]  step_q, step_d;
  logic [DIGIT_W-1:0] digit_q, digit_d;
  logic               leg_end, step_end;

  assign leg_end  = (leg_q == IDX_W'(LEG_COUNT - 1));
  assign step_end = (step_q == STEP_W'(SOLVE_STEPS - 1));

  always_comb begin
    state_d    = state_q;
    leg_d      = leg_q;
    step_d     = step_q;
    digit_d    = digit_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (sts_i.in_last) begin
            leg_d   = '0;
            step_d  = '0;
            state_d = ST_ACC;
          end
        end
      end
      ST_ACC: begin
        cmd_o.acc_en = 1'b1;
        if (leg_end) begin
          leg_d   = '0;
          state_d = ST_RES;
        end else begin
          leg_d = leg_q + 1'b1;
        end
      end
      ST_RES: begin
        cmd_o.res_en = 1'b1;
        state_d      = ST_MUL;
      end
      ST_MUL, ST_UPD: begin
        if (state_q == ST_MUL && sts_i.contact) begin
          cmd_o.mul_en = 1'b1;
          state_d      = ST_DOT;
        end else begin
          cmd_o.upd_en = (state_q == ST_UPD);
          if (leg_end) begin
            leg_d = '0;
            if (step_end) begin
              state_d = ST_BMUL;
            end else begin
              step_d  = step_q + 1'b1;
              state_d = ST_ACC;
            end
          end else begin
            leg_d   = leg_q + 1'b1;
            state_d = ST_MUL;
          end
        end
      end
      ST_DOT: begin
        cmd_o.dot_en = 1'b1;
        digit_d      = '0;
        state_d      = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_en = 1'b1;
        digit_d      = digit_q + 1'b1;
        if (digit_q == DIGIT_W'(NIB_CNT - 1)) begin
          state_d = ST_UPD;
        end
      end
      ST_BMUL: begin
        cmd_o.bmul_en = 1'b1;
        state_d       = ST_BOUT;
      end
      ST_BOUT: begin
        if (sts_i.out_free) begin
          cmd_o.bout_en = 1'b1;
          if (leg_end) begin
            leg_d   = '0;
            state_d = ST_IDLE;
          end else begin
            leg_d   = leg_q + 1'b1;
            state_d = ST_BMUL;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      leg_q   <= '0;
      step_q  <= '0;
      digit_q <= '0;
    end else begin
      state_q <= state_d;
      leg_q   <= leg_d;
      step_q  <= step_d;
      digit_q <= digit_d;
    end
  end

  assign leg_o = leg_q;

`ifndef SYNTHESIS
  a_leg_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    leg_q <= IDX_W'(LEG_COUNT - 1))
    else $error("leg index out of range");
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= STEP_W'(SOLVE_STEPS - 1))
    else $error("solve step out of range");
  a_upd_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_UPD |-> $past(state_q) == ST_DIV && $past(digit_q) == DIGIT_W'(NIB_CNT - 1))
    else $error("update without full divide");
  a_out_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.bout_en |-> sts_i.out_free)
    else $error("result loaded over a pending one");
`endif

endmodule

`default_nettype wire

FILE: tb/contact_force_allocator_test.sv
// Testbench: contact force allocator, checked against a cycle-free predictor of the solve.
`timescale 1ns / 100ps
`default_nettype none

module contact_force_allocator_test;
  import cfa_pkg::*;

  localparam int unsigned LEGS  = LEG_COUNT_DEF;
  localparam int unsigned STEPS = SOLVE_STEPS_DEF;
  // About 300 items give about 60 solves, plus stalls and gaps. Allow plenty.
  localparam longint CYCLE_LIMIT = 3000000;
  localparam int     DRAIN_CYCLES = 50;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [31:0] cfg_data = '0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  contact_force_allocator u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data)
  );

  always #1 clk = ~clk;

  // Predictor state
  logic [31:0]        limit_q;
  logic [31:0]        held_force [LEGS];
  logic signed [15:0] roll_q [LEGS];
  logic signed [15:0] pitch_q [LEGS];
  logic [LEGS-1:0]    contacts;
  int unsigned        slot_q;
  out_item_t          force_queue [$];

  int  errors = 0;
  int  stall_left = 0;
  bit  calm = 1'b0;      // no idling in the final stretch
  longint cycles = 0;

  function automatic longint fdiv(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q--;
    return q;
  endfunction

  function automatic logic signed [15:0] lever_ratio(longint cm);
    longint n, mag, q;
    n = cm * 4096;
    mag = n < 0 ? -n : n;
    q = (2 * mag + 125) / 250;
    if (n < 0) q = -q;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return 16'(q);
  endfunction

  // Record one leg; on the last leg, solve the run and queue the expected support forces
  task automatic predict_item(input in_item_t it);
    longint wf [LEGS];
    longint lift, roll, pitch, bl, sf, sr, sp, rl, rr, rp, dot, f, s, n;
    roll_q[slot_q]  = lever_ratio(longint'(it.arm_y));
    pitch_q[slot_q] = lever_ratio(-longint'(it.arm_x));
    contacts[slot_q] = it.in_contact;
    if (!it.last_leg) begin
      slot_q = (slot_q + 1) % LEGS;
      return;
    end
    slot_q = 0;
    lift  = longint'(it.demand_lift);
    roll  = longint'(it.demand_roll);
    pitch = longint'(it.demand_pitch);
    bl    = longint'(it.blend);
    if (bl > BLEND_ONE) bl = BLEND_ONE;
    for (int i = 0; i < LEGS; i++) wf[i] = longint'(held_force[i]);
    for (int k = 0; k < STEPS; k++) begin
      sf = 0; sr = 0; sp = 0;
      for (int i = 0; i < LEGS; i++) if (contacts[i]) begin
        sf += wf[i];
        sr += longint'(roll_q[i]) * wf[i];
        sp += longint'(pitch_q[i]) * wf[i];
      end
      rl = lift - sf;
      rr = roll - fdiv(sr, 16384);
      rp = pitch - fdiv(sp, 16384);
      for (int i = 0; i < LEGS; i++) if (contacts[i]) begin
        dot = rl + fdiv(longint'(roll_q[i]) * rr, 16384)
                 + fdiv(longint'(pitch_q[i]) * rp, 16384);
        f = wf[i] + fdiv(dot, STEP_DIV);
        if (f < 0) f = 0;
        if (f > longint'(limit_q)) f = longint'(limit_q);
        wf[i] = f;
      end
    end
    for (int i = 0; i < LEGS; i++) begin
      if (contacts[i]) begin
        s = longint'(held_force[i]);
        n = s + fdiv((wf[i] - s) * bl, 65536);
        if (n < 0) n = 0;
        if (n > 64'hFFFF_FFFF) n = 64'hFFFF_FFFF;
        held_force[i] = 32'(n);
      end else begin
        held_force[i] = '0;
      end
      force_queue.push_back('{leg_number: 3'(i), support_force: held_force[i],
                              last: (i == LEGS - 1)});
    end
  endtask

  task automatic idle_burst();
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
  endtask

  // Send one leg transaction; valid stays high between back-to-back items
  task automatic send_leg(input in_item_t it);
    idle_burst();
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_item(it);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (force_queue.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_limit(input logic [31:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    limit_q = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic in_item_t rand_leg(input bit last);
    in_item_t it;
    it.arm_x        = 12'($urandom);
    it.arm_y        = 12'($urandom);
    it.in_contact   = ($urandom_range(0, 4) != 0);
    it.demand_lift  = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 200000);
    it.demand_roll  = $urandom_range(0, 3) == 0 ? $urandom : 32'($urandom_range(0, 80000) - 40000);
    it.demand_pitch = $urandom_range(0, 3) == 0 ? $urandom : 32'($urandom_range(0, 80000) - 40000);
    it.blend        = $urandom_range(0, 7) == 0 ? 17'($urandom) : 17'($urandom_range(0, 65536));
    it.last_leg     = last;
    return it;
  endfunction

  // Response side: stalls in random bursts, compare against the oldest expectation
  always @(negedge clk) begin
    if (rst_n) begin
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        stall_left = $urandom_range(0, 2);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    cycles <= cycles + 1;
    if (rst_n && out_valid && out_ready) begin
      if (force_queue.size() == 0) begin
        $error("unexpected result: leg %0d force %0d", out_data.leg_number,
               out_data.support_force);
        errors++;
      end else begin
        want = force_queue.pop_front();
        if (out_data.leg_number !== want.leg_number) begin
          $error("leg_number: expected %0d, got %0d", want.leg_number, out_data.leg_number);
          errors++;
        end
        if (out_data.support_force !== want.support_force) begin
          $error("support_force: expected %0d, got %0d", want.support_force,
                 out_data.support_force);
          errors++;
        end
        if (out_data.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, out_data.last);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("contact_force_allocator_test: done, errors");
      $finish;
    end
  end

  // Full six-leg run with extreme arms and demands, blend above one, then a zeroed run with leg 2 lifted
  task automatic test_extremes();
    in_item_t it;
    for (int i = 0; i < LEGS; i++) begin
      it = rand_leg(i == LEGS - 1);
      it.arm_x = (i % 2) ? 12'h800 : 12'h7FF;
      it.arm_y = (i % 3 == 0) ? 12'h800 : 12'h7FF;
      it.in_contact = 1'b1;
      it.demand_lift = 32'hFFFF_FFFF;
      it.demand_roll = 32'h7FFF_FFFF;
      it.demand_pitch = 32'h8000_0000;
      it.blend = 17'h1FFFF;
      send_leg(it);
    end
    for (int i = 0; i < LEGS; i++) begin
      it = rand_leg(i == LEGS - 1);
      it.arm_x = 12'h000; it.arm_y = 12'h000;
      it.in_contact = (i != 2);
      it.demand_lift = '0; it.demand_roll = '0; it.demand_pitch = '0;
      it.blend = 17'd65536;
      send_leg(it);
    end
  endtask

  // Last leg arrives early; untouched slots keep their old data
  task automatic test_early_last();
    send_leg(rand_leg(1'b0));
    send_leg(rand_leg(1'b1));
    send_leg(rand_leg(1'b1));
  endtask

  // Counter wraps past the last slot without a last_leg transaction
  task automatic test_counter_wrap();
    for (int i = 0; i < LEGS + 2; i++) send_leg(rand_leg(1'b0));
    send_leg(rand_leg(1'b1));
  endtask

  // Blend of zero keeps stored forces; all legs lifted clears them
  task automatic test_blend_and_lift_off();
    in_item_t it;
    for (int i = 0; i < LEGS; i++) begin
      it = rand_leg(i == LEGS - 1);
      it.blend = '0;
      send_leg(it);
    end
    for (int i = 0; i < LEGS; i++) begin
      it = rand_leg(i == LEGS - 1);
      it.in_contact = 1'b0;
      send_leg(it);
    end
  endtask

  // Mostly full runs with random content, some short or overlong runs
  task automatic test_random(input int n_items);
    int sent;
    int len;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, LEGS + 3) : LEGS;
      for (int i = 0; i < len; i++) send_leg(rand_leg(i == len - 1));
      sent += len;
      if ($urandom_range(0, 9) == 0) wait_idle();   // sender holds off for drain
    end
  endtask

  initial begin
    limit_q = 32'hFFFF_FFFF;
    foreach (held_force[i]) begin
      held_force[i] = '0; roll_q[i] = '0; pitch_q[i] = '0;
    end
    contacts = '0;
    slot_q = 0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_extremes();
    test_early_last();
    test_counter_wrap();
    test_blend_and_lift_off();
    wait_idle();

    write_limit(32'd0);
    test_random(60);
    wait_idle();
    write_limit(32'd5000);
    test_random(60);
    wait_idle();
    write_limit($urandom);
    test_random(60);
    wait_idle();
    write_limit(32'hFFFF_FFFF);
    test_random(60);
    calm = 1'b1;
    test_random(40);
    wait_idle();

    if (errors == 0) begin
      $display("contact_force_allocator_test: done, clean");
    end else begin
      $display("contact_force_allocator_test: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
